@@ rtl/core/diq_pkg.sv @@
// shared types, constants and basis table for the dequant / idct / row predict block
package diq_pkg;
   localparam int N = 4;
   localparam int NN = 16;
   localparam int FRAC = 14;
   localparam int LVL_W = 12;
   localparam int STEP_W = 7;
   localparam int COEF_W = 18;
   localparam int RES_W = 20;
   localparam int SMP_W = 22;
   localparam int IDX_W = 4;
   localparam int N_W = 2;
   localparam int QD = 2;
   localparam logic [STEP_W-1:0] STEP_RESET = 7'd8;

   // basis[u][x] in Q14: 8192, 10703/4433, 8192, 4433/10703
   function automatic logic signed [15:0] basis(input logic [N_W-1:0] u,
                                                input logic [N_W-1:0] x);
      logic signed [15:0] b;
      case ({u, x})
         4'h0, 4'h1, 4'h2, 4'h3: b = 16'sd8192;
         4'h4: b = 16'sd10703;
         4'h5: b = 16'sd4433;
         4'h6: b = -16'sd4433;
         4'h7: b = -16'sd10703;
         4'h8, 4'hb: b = 16'sd8192;
         4'h9, 4'ha: b = -16'sd8192;
         4'hc: b = 16'sd4433;
         4'hd: b = -16'sd10703;
         4'he: b = 16'sd10703;
         4'hf: b = -16'sd4433;
         default: b = 16'sd0;
      endcase
      return b;
   endfunction

   typedef struct packed {
      logic signed [COEF_W-1:0] coef;
      logic last;
   } coef_beat_type;
endpackage

@@ rtl/core/diq_front.sv @@
// front: accepts levels, dequantizes and tags the block's last beat
module diq_front import diq_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic [STEP_W-1:0] step,
   input  logic in_valid,
   output logic in_ready,
   input  logic signed [LVL_W-1:0] level,
   output logic out_valid,
   input  logic out_ready,
   output coef_beat_type out_beat
);
   logic [IDX_W-1:0] cnt_ff, cnt_in;
   logic [QD-1:0] wp_ff, wp_in, rp_ff, rp_in;
   logic [QD:0] fill_ff, fill_in;
   coef_beat_type q_ff [2**QD];
   logic signed [LVL_W+STEP_W:0] prod;
   coef_beat_type b;
   logic push, pop;

   assign prod = level * $signed({1'b0, step});
   always_comb begin
      if (prod > $signed(20'sd131071)) b.coef = 18'sh1ffff;
      else if (prod < $signed(-20'sd131072)) b.coef = 18'sh20000;
      else b.coef = prod[COEF_W-1:0];
      b.last = (cnt_ff == IDX_W'(NN - 1));
   end

   assign in_ready = (fill_ff != (QD+1)'(2**QD));
   assign out_valid = (fill_ff != '0);
   assign out_beat = q_ff[rp_ff];
   assign push = in_valid && in_ready;
   assign pop = out_valid && out_ready;
   assign cnt_in = push ? cnt_ff + 1'b1 : cnt_ff;
   assign wp_in = push ? wp_ff + 1'b1 : wp_ff;
   assign rp_in = pop ? rp_ff + 1'b1 : rp_ff;
   assign fill_in = fill_ff + (QD+1)'(push) - (QD+1)'(pop);

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0; wp_ff <= '0; rp_ff <= '0; fill_ff <= '0;
      end else begin
         cnt_ff <= cnt_in; wp_ff <= wp_in; rp_ff <= rp_in; fill_ff <= fill_in;
      end
      if (push) q_ff[wp_ff] <= b;
   end
endmodule

@@ rtl/core/diq_back.sv @@
// back: coefficient store, shared multiply-accumulate transform, row sum output
module diq_back import diq_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic in_valid,
   output logic in_ready,
   input  coef_beat_type in_beat,
   output logic out_valid,
   input  logic out_ready,
   output logic signed [SMP_W-1:0] sample,
   output logic last
);
   typedef enum logic [3:0] {
      LOAD = 4'b0001, MAC = 4'b0010, FIN = 4'b0100, EMIT = 4'b1000
   } st_type;
   st_type st_ff, st_in;
   logic signed [COEF_W-1:0] coef_ff [NN];
   logic [IDX_W-1:0] ld_ff, k_ff, t_ff, k_in, t_in;
   logic signed [49:0] acc_ff, acc_in;
   logic signed [31:0] bb_ff;
   logic signed [COEF_W-1:0] c_ff;
   logic p_ff;
   logic signed [49:0] term;
   logic signed [49:0] mag, rnd;
   logic signed [RES_W-1:0] res;
   logic signed [SMP_W:0] sum;
   logic signed [SMP_W-1:0] row_ff, row_in;
   logic ov_ff;
   logic lst_ff;

   assign in_ready = (st_ff == LOAD);
   assign term = bb_ff * c_ff;
   // round half away from zero, then saturate to 20 bits
   always_comb begin
      mag = acc_ff < 0 ? -acc_ff : acc_ff;
      rnd = (mag + 50'sd8192 * 2 * 8192) >>> (2 * FRAC);
      if (acc_ff < 0) rnd = -rnd;
      if (rnd > 50'sd524287) res = 20'sh7ffff;
      else if (rnd < -50'sd524288) res = 20'sh80000;
      else res = rnd[RES_W-1:0];
      sum = (k_ff[N_W-1:0] == '0) ? (SMP_W+1)'(res) : row_ff + res;
      if (sum > 23'sd2097151) row_in = 22'sh1fffff;
      else if (sum < -23'sd2097152) row_in = 22'sh200000;
      else row_in = sum[SMP_W-1:0];
   end

   assign out_valid = ov_ff;
   assign sample = row_ff;
   // flag held with the sample, since k moves on while the sample waits
   assign last = ov_ff && lst_ff;

   always_comb begin
      st_in = st_ff; k_in = k_ff; t_in = t_ff; acc_in = acc_ff;
      case (st_ff)
         LOAD: if (in_valid && in_beat.last) begin
            st_in = MAC; k_in = '0; t_in = '0; acc_in = '0;
         end
         MAC: begin
            if (p_ff) acc_in = acc_ff + term;
            t_in = t_ff + 1'b1;
            if (t_ff == IDX_W'(NN - 1)) st_in = FIN;
         end
         FIN: begin
            if (p_ff) acc_in = acc_ff + term;
            st_in = EMIT;
         end
         EMIT: if (!ov_ff || out_ready) begin
            acc_in = '0;
            if (k_ff == IDX_W'(NN - 1)) st_in = LOAD;
            else begin
               k_in = k_ff + 1'b1; st_in = MAC;
            end
         end
         default: st_in = LOAD;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         st_ff <= LOAD; ld_ff <= '0; p_ff <= 1'b0; ov_ff <= 1'b0; row_ff <= '0;
         lst_ff <= 1'b0;
      end else begin
         st_ff <= st_in;
         p_ff <= (st_ff == MAC);
         if (in_valid && in_ready) ld_ff <= ld_ff + 1'b1;
         if (st_ff == EMIT && (!ov_ff || out_ready)) begin
            ov_ff <= 1'b1; row_ff <= row_in;
            lst_ff <= (k_ff == IDX_W'(NN - 1));
         end else if (ov_ff && out_ready) ov_ff <= 1'b0;
      end
      k_ff <= k_in; t_ff <= t_in; acc_ff <= acc_in;
      if (in_valid && in_ready) coef_ff[ld_ff] <= in_beat.coef;
      // term index t = u*4+v; output k = x*4+y
      bb_ff <= basis(t_ff[3:2], k_ff[3:2]) * basis(t_ff[1:0], k_ff[1:0]);
      c_ff <= coef_ff[t_ff];
   end
endmodule

@@ rtl/core/dequant_idct4x4_row_predict.sv @@
// top level: dequantize, 4x4 inverse dct and row prediction undo
// first sample follows the sixteenth level beat via the MAC, FIN and EMIT states
// 16 level beats load at one a cycle in LOAD, then 16 samples before the next block
// one shared coefficient multiplier and accumulator, 16 products per sample
// reset is synchronous and active high: clears the beat count, queue and row sum
// quant_step resets to 8
module dequant_idct4x4_row_predict import diq_pkg::*; (
   input  logic clock,
   input  logic reset,
   input  logic req_tvalid,
   output logic req_tready,
   input  logic [15:0] req_tdata,   // [11:0] level
   output logic rsp_tvalid,
   input  logic rsp_tready,
   output logic [23:0] rsp_tdata,   // [21:0] sample
   output logic rsp_tlast,          // last_of_block
   input  logic csr_valid,
   output logic csr_ready,
   input  logic [STEP_W-1:0] csr_data
);
   logic [STEP_W-1:0] step_ff;
   logic q_valid, q_ready;
   coef_beat_type q_beat;
   logic signed [SMP_W-1:0] smp;

   assign csr_ready = 1'b1;
   always_ff @(posedge clock) begin
      if (reset) step_ff <= STEP_RESET;
      else if (csr_valid) step_ff <= csr_data;
   end

   // front part: dequantize into the short queue
   diq_front u_front (
      .clock, .reset, .step(step_ff),
      .in_valid(req_tvalid), .in_ready(req_tready),
      .level(req_tdata[LVL_W-1:0]),
      .out_valid(q_valid), .out_ready(q_ready), .out_beat(q_beat)
   );

   // back part: transform and row sum
   diq_back u_back (
      .clock, .reset,
      .in_valid(q_valid), .in_ready(q_ready), .in_beat(q_beat),
      .out_valid(rsp_tvalid), .out_ready(rsp_tready),
      .sample(smp), .last(rsp_tlast)
   );

   assign rsp_tdata = {2'b00, smp};
endmodule

@@ rtl/core/diq_checker.sv @@
// port checker for the top level, bound in
module diq_checker (
   input logic clock,
   input logic reset,
   input logic rsp_tvalid,
   input logic rsp_tready,
   input logic [23:0] rsp_tdata,
   input logic rsp_tlast
);
   a_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid && !rsp_tready |=> rsp_tvalid && $stable(rsp_tdata)) else $error("rsp hold");
   a_pad: assert property (@(posedge clock) disable iff (reset)
      rsp_tvalid |-> rsp_tdata[23:22] == 2'b00) else $error("pad bits");
   a_last: assert property (@(posedge clock) disable iff (reset)
      rsp_tlast |-> rsp_tvalid) else $error("tlast without tvalid");
endmodule

bind dequant_idct4x4_row_predict diq_checker u_chk (
   .clock, .reset, .rsp_tvalid, .rsp_tready, .rsp_tdata, .rsp_tlast
);
